@@ sv/cdf_pkg.sv @@
// shared types and constants for the chunk stream deframer
// no dependencies; imported by the top level and the checker
package cdf_pkg;

	localparam int STREAM_SLOTS = 64;
	localparam int SLOT_W       = $clog2(STREAM_SLOTS);

	localparam logic [23:0] CHUNK_SIZE_RST = 24'd128;
	localparam logic [23:0] ESC24          = 24'hFFFFFF;
	localparam logic [5:0]  CSID_EXT1      = 6'h00;
	localparam logic [5:0]  CSID_EXT2      = 6'h01;
	localparam logic [16:0] CSID_BASE      = 17'd64;
	localparam logic [3:0]  HDR_LEN_F0     = 4'd11;
	localparam logic [3:0]  HDR_LEN_F1     = 4'd7;
	localparam logic [3:0]  HDR_LEN_F2     = 4'd3;
	localparam logic [3:0]  MSG_STREAM_POS = 4'd7;
	localparam logic [3:0]  EXT_BYTES      = 4'd4;
	localparam logic [7:0]  TYPE_SET_CHUNK = 8'd1;
	localparam logic [23:0] SET_CHUNK_LEN  = 24'd4;

	localparam logic [1:0] FMT_FULL  = 2'd0;
	localparam logic [1:0] FMT_DELTA = 2'd1;
	localparam logic [1:0] FMT_STAMP = 2'd2;
	localparam logic [1:0] FMT_NONE  = 2'd3;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_OOR   = 2'd2
	} kind_t;

	// saved per-stream message header
	typedef struct packed {
		logic [31:0] stamp;
		logic [23:0] length;
		logic [7:0]  mtype;
		logic [31:0] mstream;
		logic        ext;
	} hdr_row_t;

	// per-stream payload progress
	typedef struct packed {
		logic [23:0] rcount;
		logic [31:0] capture;
	} cnt_row_t;

	localparam int HDR_ROW_W = $bits(hdr_row_t);
	localparam int CNT_ROW_W = $bits(cnt_row_t);

endpackage

@@ sv/cdf_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module cdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/chunk_stream_deframer.sv @@
// byte-serial chunk stream deframer: header parse, per-stream header table, payload split
// depends on cdf_pkg and cdf_ram
//
// usage
//  - in channel: one raw stream byte per transfer (in_valid/in_ready/in_byte)
//  - out channel: one tagged result per transfer; kind says payload byte, empty
//    message or stream id outside the table; header fields ride with data and empty results
//  - cfg_we/cfg_wdata load the chunk size (a zero write is ignored); write only
//    while the block is idle
//  - header and byte counters of each stream live in two rams with a registered read;
//    the row of a stream is read when its basic header ends
// throughput and timing
//  - payload and message header bytes: one per cycle while the output is not stalled
//  - after the last basic header byte of a chunk that hits the table, in_ready
//    drops while the ram row is read in the lookup phase (longer while the output stalls)
//  - a result is shown in the cycle after the transfer that causes it; a format 3
//    chunk with no extended stamp and nothing to read registers its empty result
//    when the lookup phase ends, with no further input byte
// reset
//  - parser returns to the basic header, chunk size is 128, header rows and byte counts
//    read as zero until first written (per-row valid flops, no clearing pass)
// stall
//  - one output register; while it holds a result not taken, in_ready is low
module chunk_stream_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [16:0] stream_id,
	output logic [7:0]  data_byte,
	output logic [31:0] msg_timestamp,
	output logic [23:0] msg_length,
	output logic [7:0]  type_id,
	output logic [31:0] msg_stream,
	output logic        ext_stamp,
	output logic        last_of_message
);
	import cdf_pkg::*;

	// parser phases
	typedef enum logic [5:0] {
		PH_BASIC   = 6'b000001,
		PH_CSID    = 6'b000010,
		PH_LOOKUP  = 6'b000100,
		PH_MSGHDR  = 6'b001000,
		PH_EXT     = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} phase_t;

	phase_t      phase_q, nx_phase;
	logic [3:0]  cnt_q, nx_cnt;
	logic [1:0]  fmt_q, nx_fmt;
	logic        esc2_q, nx_esc2;
	logic [16:0] stream_q, nx_stream;
	logic [31:0] stamp_q, nx_stamp;
	logic [23:0] len_q, nx_len;
	logic [7:0]  type_q, nx_type;
	logic [31:0] msg_q, nx_msg;
	logic        ext_q, nx_ext;
	logic [23:0] left_q, nx_left;
	logic [23:0] active_q, nx_active;
	logic [31:0] svstamp_q, nx_svstamp;
	logic [23:0] rc_q, nx_rc;
	logic [31:0] cap_q, nx_cap;

	logic [STREAM_SLOTS-1:0] hdr_vld_q, cnt_vld_q;

	// ram ports
	hdr_row_t          hdr_wd, hdr_rd, hdr_eff;
	cnt_row_t          cnt_wd, cnt_rd;
	logic              hdr_we, cnt_we;
	logic [SLOT_W-1:0] rd_idx, cur_idx;

	// output register
	logic        ov_q;
	logic [1:0]  o_kind_q;
	logic [16:0] o_sid_q;
	logic [7:0]  o_data_q;
	logic [31:0] o_stamp_q;
	logic [23:0] o_len_q;
	logic [7:0]  o_type_q;
	logic [31:0] o_msg_q;
	logic        o_ext_q;
	logic        o_last_q;

	// step control
	logic        out_free, fire, in_fire;
	logic        do_begin, do_finish, emit, e_last;
	kind_t       e_kind;
	logic [7:0]  e_data;
	logic [23:0] remaining, rc_inc;
	logic [1:0]  msh;
	logic [31:0] cap_chk;
	logic        cnt_ok;

	assign out_free = !ov_q || out_ready;
	assign in_ready = out_free && (phase_q != PH_LOOKUP);
	assign in_fire  = in_valid && in_ready;
	// the lookup phase advances without a transfer
	assign fire     = in_fire || (phase_q == PH_LOOKUP && out_free);

	assign cur_idx = stream_q[SLOT_W-1:0];
	assign rd_idx  = nx_stream[SLOT_W-1:0];
	assign hdr_eff = hdr_vld_q[cur_idx] ? hdr_rd : '0;
	assign cnt_ok  = cnt_vld_q[cur_idx];
	assign msh     = 2'(cnt_q - MSG_STREAM_POS);
	assign rc_inc  = rc_q + 24'd1;

	always_comb begin
		nx_phase   = phase_q;
		nx_cnt     = cnt_q;
		nx_fmt     = fmt_q;
		nx_esc2    = esc2_q;
		nx_stream  = stream_q;
		nx_stamp   = stamp_q;
		nx_len     = len_q;
		nx_type    = type_q;
		nx_msg     = msg_q;
		nx_ext     = ext_q;
		nx_left    = left_q;
		nx_active  = active_q;
		nx_svstamp = svstamp_q;
		nx_rc      = rc_q;
		nx_cap     = cap_q;
		hdr_we     = 1'b0;
		hdr_wd     = '0;
		cnt_we     = 1'b0;
		cnt_wd     = '0;
		do_begin   = 1'b0;
		do_finish  = 1'b0;
		emit       = 1'b0;
		e_kind     = KIND_DATA;
		e_data     = '0;
		e_last     = 1'b0;
		remaining  = '0;
		cap_chk    = cap_q;

		unique case (phase_q)
			PH_BASIC: begin
				nx_fmt    = in_byte[7:6];
				nx_stream = {11'd0, in_byte[5:0]};
				nx_cnt    = '0;
				if (in_byte[5:0] == CSID_EXT1 || in_byte[5:0] == CSID_EXT2) begin
					nx_esc2  = (in_byte[5:0] == CSID_EXT2);
					nx_phase = PH_CSID;
				end else begin
					do_begin = 1'b1;
				end
			end
			PH_CSID: begin
				if (cnt_q == '0) begin
					nx_stream = CSID_BASE + {9'd0, in_byte};
					if (esc2_q) begin
						nx_esc2 = 1'b0;
						nx_cnt  = 4'd1;
					end else begin
						do_begin = 1'b1;
					end
				end else begin
					nx_stream = stream_q + {1'b0, in_byte, 8'd0};
					do_begin  = 1'b1;
				end
			end
			PH_LOOKUP: begin
				// row of the stream is in the read registers now
				nx_stamp   = '0;
				nx_ext     = 1'b0;
				nx_len     = (fmt_q == FMT_FULL) ? '0 : hdr_eff.length;
				nx_type    = (fmt_q == FMT_FULL) ? '0 : hdr_eff.mtype;
				nx_msg     = (fmt_q == FMT_FULL) ? '0 : hdr_eff.mstream;
				nx_svstamp = hdr_eff.stamp;
				nx_rc      = cnt_ok ? cnt_rd.rcount : '0;
				nx_cap     = cnt_rd.capture;
				if (fmt_q != FMT_NONE) begin
					nx_phase = PH_MSGHDR;
				end else if (hdr_eff.ext) begin
					nx_ext   = 1'b1;
					nx_phase = PH_EXT;
				end else begin
					nx_stamp  = hdr_eff.stamp;
					do_finish = 1'b1;
				end
			end
			PH_MSGHDR: begin
				if (cnt_q < 4'd3) begin
					nx_stamp = {8'd0, stamp_q[15:0], in_byte};
				end else if (cnt_q < 4'd6) begin
					nx_len = {len_q[15:0], in_byte};
				end else if (cnt_q == 4'd6) begin
					nx_type = in_byte;
				end else begin
					nx_msg = msg_q | ({24'd0, in_byte} << {msh, 3'd0});
				end
				nx_cnt = cnt_q + 4'd1;
				if ((fmt_q == FMT_FULL  && nx_cnt == HDR_LEN_F0) ||
				    (fmt_q == FMT_DELTA && nx_cnt == HDR_LEN_F1) ||
				    (fmt_q == FMT_STAMP && nx_cnt == HDR_LEN_F2)) begin
					nx_cnt = '0;
					if (nx_stamp[23:0] == ESC24) begin
						nx_ext   = 1'b1;
						nx_stamp = '0;
						nx_phase = PH_EXT;
					end else begin
						nx_ext    = 1'b0;
						do_finish = 1'b1;
					end
				end
			end
			PH_EXT: begin
				nx_stamp = {stamp_q[23:0], in_byte};
				nx_cnt   = cnt_q + 4'd1;
				if (nx_cnt == EXT_BYTES) begin
					do_finish = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				nx_rc   = rc_inc;
				nx_cap  = {cap_q[23:0], in_byte};
				cap_chk = nx_cap;
				nx_left = left_q - 24'd1;
				e_last  = (rc_inc >= len_q);
				emit    = 1'b1;
				e_kind  = KIND_DATA;
				e_data  = in_byte;
				if (nx_left == '0) begin
					nx_phase = PH_BASIC;
					if (e_last) begin
						nx_rc = '0;
						if (type_q == TYPE_SET_CHUNK && len_q == SET_CHUNK_LEN &&
						    cap_chk[31:24] == '0 && cap_chk[23:0] != '0) begin
							nx_active = cap_chk[23:0];
						end
					end
				end
				cnt_we = 1'b1;
				cnt_wd = '{rcount: nx_rc, capture: nx_cap};
			end
			default: begin
				nx_phase = PH_BASIC;
			end
		endcase

		// basic header done: out-of-table ids are flagged, others read their row
		if (do_begin) begin
			nx_cnt = '0;
			if (nx_stream >= 17'(STREAM_SLOTS)) begin
				nx_phase = PH_BASIC;
				emit     = 1'b1;
				e_kind   = KIND_OOR;
			end else begin
				nx_phase = PH_LOOKUP;
			end
		end

		// header complete: fold deltas, save header unless format 3, open the payload or report an empty message
		if (do_finish) begin
			if (fmt_q == FMT_DELTA || fmt_q == FMT_STAMP) begin
				nx_stamp = nx_svstamp + nx_stamp;
			end
			if (fmt_q != FMT_NONE) begin
				hdr_we = 1'b1;
				hdr_wd = '{stamp: nx_stamp, length: nx_len, mtype: nx_type,
				           mstream: nx_msg, ext: nx_ext};
			end
			nx_cnt    = '0;
			nx_phase  = PH_BASIC;
			remaining = (nx_len > nx_rc) ? nx_len - nx_rc : '0;
			if (remaining == '0) begin
				// nothing left to read: empty completion
				nx_rc  = '0;
				cnt_we = 1'b1;
				cnt_wd = '{rcount: '0, capture: nx_cap};
				if (nx_type == TYPE_SET_CHUNK && nx_len == SET_CHUNK_LEN &&
				    nx_cap[31:24] == '0 && nx_cap[23:0] != '0) begin
					nx_active = nx_cap[23:0];
				end
				emit   = 1'b1;
				e_kind = KIND_EMPTY;
				e_last = 1'b1;
			end else begin
				nx_left  = (remaining < active_q) ? remaining : active_q;
				nx_phase = PH_PAYLOAD;
			end
		end
	end

	cdf_ram #(.WIDTH(HDR_ROW_W), .DEPTH(STREAM_SLOTS)) u_hdr_ram (
		.clk   (clk),
		.we    (hdr_we && fire),
		.waddr (cur_idx),
		.wdata (hdr_wd),
		.raddr (rd_idx),
		.rdata (hdr_rd)
	);

	cdf_ram #(.WIDTH(CNT_ROW_W), .DEPTH(STREAM_SLOTS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we && fire),
		.waddr (cur_idx),
		.wdata (cnt_wd),
		.raddr (rd_idx),
		.rdata (cnt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_BASIC;
			cnt_q     <= '0;
			fmt_q     <= '0;
			esc2_q    <= 1'b0;
			stream_q  <= '0;
			stamp_q   <= '0;
			len_q     <= '0;
			type_q    <= '0;
			msg_q     <= '0;
			ext_q     <= 1'b0;
			left_q    <= '0;
			active_q  <= CHUNK_SIZE_RST;
			svstamp_q <= '0;
			rc_q      <= '0;
			cap_q     <= '0;
			hdr_vld_q <= '0;
			cnt_vld_q <= '0;
			ov_q      <= 1'b0;
		end else begin
			if (fire) begin
				phase_q   <= nx_phase;
				cnt_q     <= nx_cnt;
				fmt_q     <= nx_fmt;
				esc2_q    <= nx_esc2;
				stream_q  <= nx_stream;
				stamp_q   <= nx_stamp;
				len_q     <= nx_len;
				type_q    <= nx_type;
				msg_q     <= nx_msg;
				ext_q     <= nx_ext;
				left_q    <= nx_left;
				svstamp_q <= nx_svstamp;
				rc_q      <= nx_rc;
				cap_q     <= nx_cap;
				if (hdr_we) begin
					hdr_vld_q[cur_idx] <= 1'b1;
				end
				if (cnt_we) begin
					cnt_vld_q[cur_idx] <= 1'b1;
				end
			end
			// the user must write the chunk size only while idle; the block does not enforce it
			if (cfg_we && cfg_wdata != '0) begin
				active_q <= cfg_wdata;
			end else if (fire) begin
				active_q <= nx_active;
			end
			if (fire && emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// result payload; out-of-table results carry only the stream id
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			o_kind_q  <= e_kind;
			o_sid_q   <= nx_stream;
			o_data_q  <= e_data;
			o_last_q  <= e_last;
			if (e_kind == KIND_OOR) begin
				o_stamp_q <= '0;
				o_len_q   <= '0;
				o_type_q  <= '0;
				o_msg_q   <= '0;
				o_ext_q   <= 1'b0;
			end else begin
				o_stamp_q <= nx_stamp;
				o_len_q   <= nx_len;
				o_type_q  <= nx_type;
				o_msg_q   <= nx_msg;
				o_ext_q   <= nx_ext;
			end
		end
	end

	assign out_valid       = ov_q;
	assign kind            = o_kind_q;
	assign stream_id       = o_sid_q;
	assign data_byte       = o_data_q;
	assign msg_timestamp   = o_stamp_q;
	assign msg_length      = o_len_q;
	assign type_id         = o_type_q;
	assign msg_stream      = o_msg_q;
	assign ext_stamp       = o_ext_q;
	assign last_of_message = o_last_q;

endmodule

@@ sv/cdf_checker.sv @@
// port-level checks for the chunk stream deframer, bound to the top level
// depends on cdf_pkg
module cdf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  data_byte,
	input logic [23:0] msg_length,
	input logic [31:0] msg_timestamp,
	input logic        last_of_message
);
	import cdf_pkg::*;

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte))
		else $error("result changed while stalled");

	// a stalled result blocks new input
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EMPTY |-> last_of_message && data_byte == '0)
		else $error("empty message result malformed");

	a_oor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_OOR |->
			!last_of_message && msg_length == '0 && msg_timestamp == '0)
		else $error("out-of-table result carries header fields");

endmodule

bind chunk_stream_deframer cdf_checker u_cdf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.kind            (kind),
	.data_byte       (data_byte),
	.msg_length      (msg_length),
	.msg_timestamp   (msg_timestamp),
	.last_of_message (last_of_message)
);
